// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/rgp_pkg.sv =====
package rgp_pkg;

    // Register indexes
    localparam logic [2:0] REG_HRES   = 3'd0;
    localparam logic [2:0] REG_VRES   = 3'd1;
    localparam logic [2:0] REG_TILES  = 3'd2;
    localparam logic [2:0] REG_FIRST  = 3'd3;
    localparam logic [2:0] REG_STEP   = 3'd4;
    localparam logic [2:0] REG_MODEL  = 3'd5;
    localparam logic [2:0] REG_BITS   = 3'd6;
    localparam logic [2:0] REG_LAYOUT = 3'd7;

    // Color models
    localparam logic [1:0] MODEL_INDEXED = 2'd0;
    localparam logic [1:0] MODEL_DIRECT  = 2'd1;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        CFG_LOAD,
        CFG_DIV,
        CFG_IDLE
    } cfg_state_t;

    // Tile geometry from the setup divider
    typedef struct packed {
        logic [11:0] tile_w;
        logic [11:0] tile_h;
        logic [11:0] grid_w;
        logic [11:0] grid_h;
    } tile_cfg_t;

    // Pixel and color settings
    typedef struct packed {
        logic [7:0]  tiles;
        logic [7:0]  step;
        logic [31:0] first;
        logic [1:0]  model;
        logic [5:0]  bits;
        logic [2:0]  bytes;
        logic [26:0] layout;
        logic [11:0] width;
    } pix_cfg_t;

    // One classified pixel between front and back
    typedef struct packed {
        logic        drawn;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [10:0] x;
        logic [10:0] y;
    } tile_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ===== hw/rtl/rgp_cfg.sv =====
module rgp_cfg
    import rgp_pkg::*;
#(
    parameter int MAX_RES = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output tile_cfg_t   tile,
    output pix_cfg_t    pix,
    output logic        busy
);

    logic [11:0] hres_reg, vres_reg;
    logic [7:0]  tiles_reg, step_reg;
    logic [31:0] first_reg;
    logic [1:0]  model_reg;
    logic [5:0]  bits_reg;
    logic [26:0] layout_reg;

    cfg_state_t  state_reg, state_next;
    logic [3:0]  cnt_reg;
    logic [11:0] hq_reg, vq_reg;
    logic [7:0]  hr_reg, vr_reg;
    tile_cfg_t   tile_reg;

    logic [11:0] hc, vc;
    logic [5:0]  eff_bits;
    logic        load, step, last;
    logic [8:0]  ht, vt;
    logic        hge, vge;
    logic [7:0]  hr_next, vr_next;
    logic [11:0] hq_next, vq_next;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hres_reg   <= 12'd1024;
            vres_reg   <= 12'd768;
            tiles_reg  <= 8'd1;
            first_reg  <= 32'd0;
            step_reg   <= 8'd1;
            model_reg  <= MODEL_INDEXED;
            bits_reg   <= 6'd8;
            layout_reg <= 27'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HRES:   hres_reg   <= cfg_data[11:0];
                REG_VRES:   vres_reg   <= cfg_data[11:0];
                REG_TILES:  tiles_reg  <= cfg_data[7:0];
                REG_FIRST:  first_reg  <= cfg_data;
                REG_STEP:   step_reg   <= cfg_data[7:0];
                REG_MODEL:  model_reg  <= cfg_data[1:0];
                REG_BITS:   bits_reg   <= cfg_data[5:0];
                REG_LAYOUT: layout_reg <= cfg_data[26:0];
                default:    ;
            endcase
        end
    end

    // Clamped resolution and bits per pixel
    always_comb
    begin
        hc = (int'(hres_reg) > MAX_RES) ? 12'(MAX_RES) : hres_reg;
        vc = (int'(vres_reg) > MAX_RES) ? 12'(MAX_RES) : vres_reg;
        if (bits_reg < 6'd8)
            eff_bits = 6'd8;
        else if (bits_reg > 6'd32)
            eff_bits = 6'd32;
        else
            eff_bits = bits_reg;
    end

    // Setup sequencer: next state
    always_comb
    begin
        case (state_reg)
            CFG_LOAD: state_next = CFG_DIV;
            CFG_DIV:  state_next = (cnt_reg == 4'd11) ? CFG_IDLE : CFG_DIV;
            CFG_IDLE: state_next = CFG_IDLE;
            default:  state_next = CFG_LOAD;
        endcase
        if (cfg_we && cfg_index <= REG_TILES)
            state_next = CFG_LOAD;
    end

    // Setup sequencer: outputs
    always_comb
    begin
        load = 1'b0;
        step = 1'b0;
        busy = 1'b1;
        case (state_reg)
            CFG_LOAD: load = 1'b1;
            CFG_DIV:  step = 1'b1;
            CFG_IDLE: busy = 1'b0;
            default:  load = 1'b1;
        endcase
        last = step && (cnt_reg == 4'd11);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CFG_LOAD;
            cnt_reg   <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                cnt_reg <= 4'd0;
            else if (step)
                cnt_reg <= cnt_reg + 4'd1;
        end
    end

    // Restoring divide of width and height by the tile count, one bit a cycle
    always_comb
    begin
        ht      = {hr_reg, hq_reg[11]};
        vt      = {vr_reg, vq_reg[11]};
        hge     = ht >= {1'b0, tiles_reg};
        vge     = vt >= {1'b0, tiles_reg};
        hr_next = hge ? 8'(ht - {1'b0, tiles_reg}) : ht[7:0];
        vr_next = vge ? 8'(vt - {1'b0, tiles_reg}) : vt[7:0];
        hq_next = {hq_reg[10:0], hge};
        vq_next = {vq_reg[10:0], vge};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hq_reg <= hc;
            vq_reg <= vc;
            hr_reg <= 8'd0;
            vr_reg <= 8'd0;
        end
        else if (step)
        begin
            hq_reg <= hq_next;
            vq_reg <= vq_next;
            hr_reg <= hr_next;
            vr_reg <= vr_next;
        end
        // grid extent is the resolution less the remainder
        if (last)
        begin
            tile_reg.tile_w <= hq_next;
            tile_reg.tile_h <= vq_next;
            tile_reg.grid_w <= hc - {4'd0, hr_next};
            tile_reg.grid_h <= vc - {4'd0, vr_next};
        end
    end

    assign tile       = tile_reg;
    assign pix.tiles  = tiles_reg;
    assign pix.step   = step_reg;
    assign pix.first  = first_reg;
    assign pix.model  = model_reg;
    assign pix.bits   = eff_bits;
    assign pix.bytes  = 3'((eff_bits + 6'd7) >> 3);
    assign pix.layout = layout_reg;
    assign pix.width  = hc;

endmodule

// ===== hw/rtl/rgp_front.sv =====
module rgp_front
    import rgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [10:0] x,
    input  logic [10:0] y,
    input  tile_cfg_t   tile,
    input  pix_cfg_t    pix,
    input  logic        busy,
    input  queue_stat_t q_stat,
    output logic        push,
    output tile_item_t  push_item
);

    localparam int STAGES = 8;

    logic              vld_reg [0:STAGES];
    logic              drawn_reg [0:STAGES];
    logic [10:0]       x_reg [0:STAGES];
    logic [10:0]       y_reg [0:STAGES];
    logic [11:0]       rx_reg [0:STAGES];
    logic [11:0]       ry_reg [0:STAGES];
    logic [7:0]        qx_reg [0:STAGES];
    logic [7:0]        qy_reg [0:STAGES];

    logic en, acc, drawn_in;

    // The whole pipe holds while its last item waits on a full queue
    assign en       = !(vld_reg[STAGES] && q_stat.full);
    assign in_ready = en && !busy;
    assign acc      = in_valid && in_ready;

    // Grid membership check
    assign drawn_in = (pix.tiles != 8'd0)
                   && (pix.model == MODEL_INDEXED || pix.model == MODEL_DIRECT)
                   && (tile.tile_w != 12'd0) && (tile.tile_h != 12'd0)
                   && ({1'b0, x} < tile.grid_w) && ({1'b0, y} < tile.grid_h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= acc;
    end

    // Load: quotient fits 8 bits for any pixel inside the grid
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            drawn_reg[0] <= drawn_in;
            x_reg[0]     <= x;
            y_reg[0]     <= y;
            rx_reg[0]    <= {9'd0, x[10:8]};
            ry_reg[0]    <= {9'd0, y[10:8]};
            qx_reg[0]    <= x[7:0];
            qy_reg[0]    <= y[7:0];
        end
    end

    // One quotient bit of column and row per stage
    for (genvar k = 0; k < STAGES; k++)
    begin : g_div
        logic [12:0] tx, ty;
        logic        gx, gy;

        assign tx = {rx_reg[k], qx_reg[k][7]};
        assign ty = {ry_reg[k], qy_reg[k][7]};
        assign gx = tx >= {1'b0, tile.tile_w};
        assign gy = ty >= {1'b0, tile.tile_h};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                drawn_reg[k+1] <= drawn_reg[k];
                x_reg[k+1]     <= x_reg[k];
                y_reg[k+1]     <= y_reg[k];
                rx_reg[k+1]    <= gx ? 12'(tx - {1'b0, tile.tile_w}) : tx[11:0];
                ry_reg[k+1]    <= gy ? 12'(ty - {1'b0, tile.tile_h}) : ty[11:0];
                qx_reg[k+1]    <= {qx_reg[k][6:0], gx};
                qy_reg[k+1]    <= {qy_reg[k][6:0], gy};
            end
        end
    end

    assign push            = en && vld_reg[STAGES];
    assign push_item.drawn = drawn_reg[STAGES];
    assign push_item.col   = qx_reg[STAGES];
    assign push_item.row   = qy_reg[STAGES];
    assign push_item.x     = x_reg[STAGES];
    assign push_item.y     = y_reg[STAGES];

endmodule

// ===== hw/rtl/rgp_queue.sv =====
module rgp_queue
    import rgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  tile_item_t  push_item,
    input  logic        pop,
    output tile_item_t  pop_item,
    output queue_stat_t stat
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    tile_item_t      mem [0:QUEUE_DEPTH-1];
    tile_item_t      pop_item_reg;
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;

    assign stat.full  = (cnt_reg == (AW+1)'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_item   = pop_item_reg;

    // Storage; the popped entry shows up on pop_item the cycle after the pop
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_item;
        if (pop)
            pop_item_reg <= mem[rd_reg];
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + AW'(1);
            if (pop)
                rd_reg <= rd_reg + AW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (AW+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (AW+1)'(1);
        end
    end

endmodule

// ===== hw/rtl/rgp_back.sv =====
module rgp_back
    import rgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  tile_item_t  q_item,
    input  queue_stat_t q_stat,
    output logic        pop,
    input  pix_cfg_t    pix,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        drawn,
    output logic [23:0] byte_offset,
    output logic [31:0] pixel_color,
    output logic [2:0]  pixel_bytes
);

    // Advance one color field, wrapping inside its size
    function automatic logic [31:0] chan(input logic [31:0] first, input logic [3:0] size,
                                         input logic [4:0] pos, input logic [16:0] add);
        logic [15:0] mask;
        logic [15:0] fld;
        logic [15:0] v;
        mask = 16'((17'd1 << size) - 17'd1);
        fld  = 16'(first >> pos) & mask;
        v    = (fld + add[15:0]) & mask;
        return {16'd0, v} << pos;
    endfunction

    logic        en;
    logic        v0_reg, v1_reg, v2_reg, v3_reg, o_vld_reg;

    logic        d1_reg;
    logic [7:0]  col1_reg;
    logic [10:0] x1_reg;
    logic [15:0] rn1_reg, cs1_reg, rs1_reg;
    logic [16:0] ss1_reg;
    logic [22:0] yh1_reg;

    logic        d2_reg;
    logic [15:0] idx2_reg;
    logic [23:0] lin2_reg;
    logic [31:0] dc2_reg;

    logic        d3_reg;
    logic [23:0] is3_reg;
    logic [23:0] off3_reg;
    logic [31:0] dc3_reg;

    logic        d_o_reg;
    logic [23:0] off_o_reg;
    logic [31:0] col_o_reg;

    logic [31:0] dcol;
    logic [26:0] off_prod;
    logic [31:0] mask;
    logic [31:0] icol;

    // Output register stage frees the pipe when taken
    assign en  = !o_vld_reg || out_ready;
    assign pop = en && !q_stat.empty;

    // v0 marks the entry held in the queue read register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= pop;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            o_vld_reg <= v3_reg;
        end
    end

    // Direct color fields, offset product and indexed color
    always_comb
    begin
        dcol = chan(pix.first, pix.layout[3:0], pix.layout[16:12], {1'b0, cs1_reg})
             | chan(pix.first, pix.layout[7:4], pix.layout[21:17], {1'b0, rs1_reg})
             | chan(pix.first, pix.layout[11:8], pix.layout[26:22], ss1_reg);
        off_prod = {3'd0, lin2_reg} * {24'd0, pix.bytes};
        mask     = (pix.bits >= 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << pix.bits) - 32'd1);
        icol     = (pix.first + {8'd0, is3_reg}) & mask;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products
            d1_reg   <= q_item.drawn;
            col1_reg <= q_item.col;
            x1_reg   <= q_item.x;
            rn1_reg  <= 16'(q_item.row) * 16'(pix.tiles);
            cs1_reg  <= 16'(q_item.col) * 16'(pix.step);
            rs1_reg  <= 16'(q_item.row) * 16'(pix.step);
            ss1_reg  <= 17'({1'b0, q_item.row} + {1'b0, q_item.col}) * 17'(pix.step);
            yh1_reg  <= 23'(q_item.y) * 23'(pix.width);
            // sums and direct color
            d2_reg   <= d1_reg;
            idx2_reg <= rn1_reg + {8'd0, col1_reg};
            lin2_reg <= {1'b0, yh1_reg} + {13'd0, x1_reg};
            dc2_reg  <= dcol;
            // index scale and offset
            d3_reg   <= d2_reg;
            is3_reg  <= 24'(idx2_reg) * 24'(pix.step);
            off3_reg <= off_prod[23:0];
            dc3_reg  <= dc2_reg;
            // result
            d_o_reg   <= d3_reg;
            off_o_reg <= d3_reg ? off3_reg : 24'd0;
            if (!d3_reg)
                col_o_reg <= 32'd0;
            else if (pix.model == MODEL_INDEXED)
                col_o_reg <= icol;
            else
                col_o_reg <= dc3_reg;
        end
    end

    assign out_valid   = o_vld_reg;
    assign drawn       = d_o_reg;
    assign byte_offset = off_o_reg;
    assign pixel_color = col_o_reg;
    assign pixel_bytes = pix.bytes;

endmodule

// ===== hw/rtl/rectangle_grid_pattern_pixel_gen.sv =====
// Channel   | Dir | Contents
// s_axis    | in  | pixel coordinate
// m_axis    | out | drawn flag, byte offset, color word, byte count
// cfg       | in  | register writes, one per cycle
//
// One pixel per cycle while the setup divider is idle and neither the queue
// nor m_axis stalls; pixels pass the tile divider, the queue read register
// and the color and offset stages, plus any wait in the 4-entry queue.
// After reset, and after any write to a resolution or the tile count, the
// setup divider loads and then divides with s_axis_tready low.
// A stall on m_axis holds the back stages; the front keeps going until the
// queue fills.
`include "assert_macros.svh"

module rectangle_grid_pattern_pixel_gen
    import rgp_pkg::*;
#(
    parameter int MAX_RESOLUTION = 2048
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // pixel_x[10:0], pixel_y[21:11]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // drawn[0], byte_offset[24:1],
                                       // pixel_color[56:25], pixel_bytes[59:57]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    tile_cfg_t   tile;
    pix_cfg_t    pix;
    logic        cfg_busy;
    queue_stat_t q_stat;
    logic        push, pop;
    tile_item_t  push_item, pop_item;
    logic        drawn;
    logic [23:0] byte_offset;
    logic [31:0] pixel_color;
    logic [2:0]  pixel_bytes;

    rgp_cfg #(.MAX_RES(MAX_RESOLUTION)) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tile      (tile),
        .pix       (pix),
        .busy      (cfg_busy)
    );

    rgp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .x         (s_axis_tdata[10:0]),
        .y         (s_axis_tdata[21:11]),
        .tile      (tile),
        .pix       (pix),
        .busy      (cfg_busy),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    rgp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (q_stat)
    );

    rgp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_item      (pop_item),
        .q_stat      (q_stat),
        .pop         (pop),
        .pix         (pix),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .drawn       (drawn),
        .byte_offset (byte_offset),
        .pixel_color (pixel_color),
        .pixel_bytes (pixel_bytes)
    );

    assign m_axis_tdata = {4'd0, pixel_bytes, pixel_color, byte_offset, drawn};

    // Checks
    `ASSERT_IMPL(a_no_accept_in_setup, clk, rst_n, s_axis_tready, !cfg_busy)
    `ASSERT_IMPL(a_undrawn_zero, clk, rst_n, m_axis_tvalid && !drawn, (~|{byte_offset, pixel_color}))
    `ASSERT_IMPL(a_queue_stat, clk, rst_n, 1'b1, !(q_stat.full && q_stat.empty))
    `ASSERT_NEXT(a_write_busy, clk, rst_n, cfg_we && cfg_index <= REG_TILES, cfg_busy)

endmodule
